@@ rtl/core/tfn_pkg.sv @@
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths, beat types and side-band types of the triangle face normal
// unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

  // Coordinate and intermediate widths.
  localparam int COORD_W = 24;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int N_W     = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int POS_W   = $clog2(MAG_W);
  localparam int NM_W    = 30;
  localparam int NM_TOP  = NM_W - 1;
  localparam int SQ_W    = 2 * NM_W + 2;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int FRAC_W  = 14;
  localparam int Q_W     = FRAC_W + 1;
  localparam int NUM_W   = NM_W + FRAC_W + 1;
  localparam int IDX_W   = 16;
  localparam int UNIT_W  = 16;
  localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(1 << FRAC_W);

  // Input beat: one triangle.
  typedef struct packed {
    logic signed [COORD_W-1:0] corner_a_x;
    logic signed [COORD_W-1:0] corner_a_y;
    logic signed [COORD_W-1:0] corner_a_z;
    logic signed [COORD_W-1:0] corner_b_x;
    logic signed [COORD_W-1:0] corner_b_y;
    logic signed [COORD_W-1:0] corner_b_z;
    logic signed [COORD_W-1:0] corner_c_x;
    logic signed [COORD_W-1:0] corner_c_y;
    logic signed [COORD_W-1:0] corner_c_z;
    logic [IDX_W-1:0]          corner_a_index;
    logic [IDX_W-1:0]          corner_b_index;
    logic [IDX_W-1:0]          corner_c_index;
  } tfn_in_t;

  // Output beat: one corner of a triangle.
  typedef struct packed {
    logic [IDX_W-1:0]         vertex_slot;
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic                     degenerate;
    logic                     last_of_triangle;
  } tfn_out_t;

  // Data that rides along the divider.
  typedef struct packed {
    logic [2:0]             neg;
    logic                   degen;
    logic [2:0][IDX_W-1:0]  idx;
  } tfn_div_side_t;

  // Data that rides along the square root.
  typedef struct packed {
    logic [2:0][NM_W-1:0] mag;
    tfn_div_side_t        info;
  } tfn_sq_side_t;

  // Result of the divider lanes.
  typedef struct packed {
    logic [2:0][UNIT_W-1:0] unit;
    tfn_div_side_t          info;
  } tfn_div_res_t;

endpackage

@@ rtl/core/tfn_isqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// tfn_isqrt_pipe
// Pipelined integer square root, one root bit per stage, with side data.
// ----------------------------------------------------------------------------
module tfn_isqrt_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [tfn_pkg::SQ_W-1:0]   in_rad,
  input  tfn_pkg::tfn_sq_side_t      in_side,
  output logic                       out_valid,
  output logic [tfn_pkg::ROOT_W-1:0] out_root,
  output tfn_pkg::tfn_sq_side_t      out_side
);
  import tfn_pkg::*;

  logic [SQ_W-1:0]   rem_r   [ROOT_W+1];
  logic [ROOT_W-1:0] root_r  [ROOT_W+1];
  tfn_sq_side_t      side_r  [ROOT_W+1];
  logic [ROOT_W:0]   vld_r;
  logic [SQ_W-1:0]   rem_nxt [ROOT_W+1];
  logic [ROOT_W-1:0] root_nxt[ROOT_W+1];

  // Each stage tries one more root bit against the running remainder.
  always_comb begin
    logic [SQ_W-1:0] trial;
    rem_nxt[0]  = in_rad;
    root_nxt[0] = '0;
    for (int k = 1; k <= ROOT_W; k++) begin
      trial = ({{(SQ_W-ROOT_W){1'b0}}, root_r[k-1]} << (ROOT_W - k + 1))
            | ({{(SQ_W-1){1'b0}}, 1'b1} << (2 * (ROOT_W - k)));
      if (rem_r[k-1] >= trial) begin
        rem_nxt[k]  = rem_r[k-1] - trial;
        root_nxt[k] = root_r[k-1] | (ROOT_W'(1) << (ROOT_W - k));
      end else begin
        rem_nxt[k]  = rem_r[k-1];
        root_nxt[k] = root_r[k-1];
      end
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ROOT_W-1:0], in_valid};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int k = 0; k <= ROOT_W; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      if (k > 0) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];
  assign out_side  = side_r[ROOT_W];

endmodule

@@ rtl/core/tfn_div_pipe.sv @@
// ----------------------------------------------------------------------------
// tfn_div_pipe
// Three-lane pipelined restoring divider that scales the normal to Q1.14.
// ----------------------------------------------------------------------------
module tfn_div_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [tfn_pkg::ROOT_W-1:0] in_len,
  input  tfn_pkg::tfn_sq_side_t      in_side,
  output logic                       out_valid,
  output tfn_pkg::tfn_div_res_t      out_res
);
  import tfn_pkg::*;

  logic [2:0][NUM_W-1:0] rem_r  [Q_W+1];
  logic [2:0][Q_W-1:0]   quo_r  [Q_W+1];
  logic [ROOT_W-1:0]     len_r  [Q_W+1];
  tfn_div_side_t         side_r [Q_W+1];
  logic [Q_W:0]          vld_r;
  logic [2:0][NUM_W-1:0] rem_nxt[Q_W+1];
  logic [2:0][Q_W-1:0]   quo_nxt[Q_W+1];

  // Stage zero forms the rounded numerator; the others take one quotient bit.
  always_comb begin
    logic [NUM_W:0] dsr;
    for (int l = 0; l < 3; l++) begin
      rem_nxt[0][l] = {1'b0, in_side.mag[l], {FRAC_W{1'b0}}}
                    + NUM_W'(in_len >> 1);
      quo_nxt[0][l] = '0;
    end
    for (int k = 1; k <= Q_W; k++) begin
      dsr = {{(NUM_W+1-ROOT_W){1'b0}}, len_r[k-1]} << (Q_W - k);
      for (int l = 0; l < 3; l++) begin
        if ({1'b0, rem_r[k-1][l]} >= dsr) begin
          rem_nxt[k][l] = rem_r[k-1][l] - dsr[NUM_W-1:0];
          quo_nxt[k][l] = quo_r[k-1][l] | (Q_W'(1) << (Q_W - k));
        end else begin
          rem_nxt[k][l] = rem_r[k-1][l];
          quo_nxt[k][l] = quo_r[k-1][l];
        end
      end
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Q_W-1:0], in_valid};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    len_r[0]  <= in_len;
    side_r[0] <= in_side.info;
    for (int k = 0; k <= Q_W; k++) begin
      rem_r[k] <= rem_nxt[k];
      quo_r[k] <= quo_nxt[k];
      if (k > 0) begin
        len_r[k]  <= len_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Clamp, apply the sign and force zero on a degenerate triangle.
  always_comb begin
    logic [Q_W-1:0] q;
    out_res.info = side_r[Q_W];
    for (int l = 0; l < 3; l++) begin
      q = (quo_r[Q_W][l] > ONE_Q14) ? ONE_Q14 : quo_r[Q_W][l];
      if (side_r[Q_W].degen) begin
        out_res.unit[l] = '0;
      end else if (side_r[Q_W].neg[l]) begin
        out_res.unit[l] = UNIT_W'(0) - UNIT_W'(q);
      end else begin
        out_res.unit[l] = UNIT_W'(q);
      end
    end
  end

  assign out_valid = vld_r[Q_W];

endmodule

@@ rtl/core/triangle_face_normal_unit.sv @@
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Unit face normal of a triangle, emitted once per corner.
// ----------------------------------------------------------------------------
// Order: the first result strobes, then the second and third follow back to back.
// Pacing: busy is high after each accept, so that the three result beats
// share the single result port; start is taken only while busy is low.
// Reset: synchronous, active low; clears all valid bits and the beat counter.
module triangle_face_normal_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tfn_pkg::tfn_in_t  in_beat,
  output logic              out_valid,
  output tfn_pkg::tfn_out_t out_beat
);
  import tfn_pkg::*;

  logic                           accept;
  logic [1:0]                     hold_r, hold_nxt;
  logic [7:1]                     v_r;
  logic signed [5:0][EDGE_W-1:0]  e_r;
  logic signed [5:0][PROD_W-1:0]  p_r;
  logic signed [2:0][N_W-1:0]     n_r;
  logic [2:0][MAG_W-1:0]          mag_r;
  logic [2:0][MAG_W-1:0]          mag5_r;
  logic [MAG_W-1:0]               or_r;
  logic [POS_W-1:0]               pos_r;
  logic [POS_W-1:0]               pos_nxt;
  logic                           degen5_r;
  logic [2:0][NM_W-1:0]           nm_r;
  logic [2:0][NM_W-1:0]           nm7_r;
  logic [2:0][SQ_W-3:0]           sq_r;
  tfn_div_side_t                  info_r [2:7];
  logic [2:0][IDX_W-1:0]          idx1_r;
  logic [SQ_W-1:0]                rad;
  tfn_sq_side_t                   sq_side;
  logic                           sq_valid;
  logic [ROOT_W-1:0]              sq_root;
  tfn_sq_side_t                   sq_side_out;
  logic                           dv_valid_sq;
  logic                           dv_valid;
  tfn_div_res_t                   dv_res;
  tfn_div_res_t                   keep_r;
  logic [1:0]                     left_r;

  // Accept one triangle, then hold off while busy is high.
  assign accept   = start && !busy;
  assign busy     = (hold_r != 2'd0);
  assign hold_nxt = accept ? 2'd2 : ((hold_r != 2'd0) ? hold_r - 2'd1 : 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
      v_r    <= '0;
    end else begin
      hold_r <= hold_nxt;
      v_r    <= {v_r[6:1], accept};
    end
  end

  // Front pipeline: edges, products, cross product, magnitudes, leading bit,
  // normalizing shift and squares.
  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (or_r[i]) begin
        pos_nxt = POS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [MAG_W-1:0] sh;
    // Edges from the first corner.
    e_r[0] <= EDGE_W'(in_beat.corner_b_x) - EDGE_W'(in_beat.corner_a_x);
    e_r[1] <= EDGE_W'(in_beat.corner_b_y) - EDGE_W'(in_beat.corner_a_y);
    e_r[2] <= EDGE_W'(in_beat.corner_b_z) - EDGE_W'(in_beat.corner_a_z);
    e_r[3] <= EDGE_W'(in_beat.corner_c_x) - EDGE_W'(in_beat.corner_a_x);
    e_r[4] <= EDGE_W'(in_beat.corner_c_y) - EDGE_W'(in_beat.corner_a_y);
    e_r[5] <= EDGE_W'(in_beat.corner_c_z) - EDGE_W'(in_beat.corner_a_z);
    idx1_r <= {in_beat.corner_c_index, in_beat.corner_b_index, in_beat.corner_a_index};
    // Partial products of the signed edges.
    p_r[0] <= PROD_W'($signed(e_r[1])) * PROD_W'($signed(e_r[5]));
    p_r[1] <= PROD_W'($signed(e_r[2])) * PROD_W'($signed(e_r[4]));
    p_r[2] <= PROD_W'($signed(e_r[2])) * PROD_W'($signed(e_r[3]));
    p_r[3] <= PROD_W'($signed(e_r[0])) * PROD_W'($signed(e_r[5]));
    p_r[4] <= PROD_W'($signed(e_r[0])) * PROD_W'($signed(e_r[4]));
    p_r[5] <= PROD_W'($signed(e_r[1])) * PROD_W'($signed(e_r[3]));
    info_r[2].idx   <= idx1_r;
    info_r[2].neg   <= '0;
    info_r[2].degen <= 1'b0;
    // Cross product.
    n_r[0] <= N_W'($signed(p_r[0])) - N_W'($signed(p_r[1]));
    n_r[1] <= N_W'($signed(p_r[2])) - N_W'($signed(p_r[3]));
    n_r[2] <= N_W'($signed(p_r[4])) - N_W'($signed(p_r[5]));
    info_r[3] <= info_r[2];
    // Magnitudes, signs and the OR that shares the top bit of the largest.
    for (int l = 0; l < 3; l++) begin
      mag_r[l] <= n_r[l][N_W-1] ? MAG_W'(-n_r[l]) : MAG_W'(n_r[l]);
    end
    or_r <= (n_r[0][N_W-1] ? MAG_W'(-n_r[0]) : MAG_W'(n_r[0]))
          | (n_r[1][N_W-1] ? MAG_W'(-n_r[1]) : MAG_W'(n_r[1]))
          | (n_r[2][N_W-1] ? MAG_W'(-n_r[2]) : MAG_W'(n_r[2]));
    info_r[4].idx   <= info_r[3].idx;
    info_r[4].neg   <= {n_r[2][N_W-1], n_r[1][N_W-1], n_r[0][N_W-1]};
    info_r[4].degen <= 1'b0;
    // Leading bit position.
    mag5_r   <= mag_r;
    pos_r    <= pos_nxt;
    degen5_r <= (or_r == '0);
    info_r[5] <= info_r[4];
    // Shift so that the largest magnitude lies in [2^29, 2^30).
    for (int l = 0; l < 3; l++) begin
      if (pos_r >= POS_W'(NM_TOP)) begin
        sh = mag5_r[l] >> (pos_r - POS_W'(NM_TOP));
      end else begin
        sh = mag5_r[l] << (POS_W'(NM_TOP) - pos_r);
      end
      nm_r[l] <= sh[NM_W-1:0];
    end
    info_r[6].idx   <= info_r[5].idx;
    info_r[6].neg   <= info_r[5].neg;
    info_r[6].degen <= degen5_r;
    // Squares.
    for (int l = 0; l < 3; l++) begin
      sq_r[l] <= (SQ_W-2)'(nm_r[l]) * (SQ_W-2)'(nm_r[l]);
    end
    nm7_r     <= nm_r;
    info_r[7] <= info_r[6];
  end

  // Sum of squares feeds the root.
  assign rad      = SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]);
  assign sq_side  = '{mag: nm7_r, info: info_r[7]};
  assign sq_valid = v_r[7];

  tfn_isqrt_pipe u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_rad    (rad),
    .in_side   (sq_side),
    .out_valid (dv_valid_sq),
    .out_root  (sq_root),
    .out_side  (sq_side_out)
  );

  tfn_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid_sq),
    .in_len    (sq_root),
    .in_side   (sq_side_out),
    .out_valid (dv_valid),
    .out_res   (dv_res)
  );

  // Result serializer: corner a, then b, then c, one beat per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      left_r    <= '0;
    end else if (dv_valid) begin
      out_valid <= 1'b1;
      left_r    <= 2'd2;
    end else if (left_r != 2'd0) begin
      out_valid <= 1'b1;
      left_r    <= left_r - 2'd1;
    end else begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_valid) begin
      keep_r                    <= dv_res;
      out_beat.vertex_slot      <= dv_res.info.idx[0];
      out_beat.unit_x           <= dv_res.unit[0];
      out_beat.unit_y           <= dv_res.unit[1];
      out_beat.unit_z           <= dv_res.unit[2];
      out_beat.degenerate       <= dv_res.info.degen;
      out_beat.last_of_triangle <= 1'b0;
    end else if (left_r != 2'd0) begin
      out_beat.vertex_slot      <= (left_r == 2'd2) ? keep_r.info.idx[1]
                                                     : keep_r.info.idx[2];
      out_beat.unit_x           <= keep_r.unit[0];
      out_beat.unit_y           <= keep_r.unit[1];
      out_beat.unit_z           <= keep_r.unit[2];
      out_beat.degenerate       <= keep_r.info.degen;
      out_beat.last_of_triangle <= (left_r == 2'd1);
    end
  end

endmodule
